// ===== src/csi_pkg.sv =====
// Shared types, constants and key helpers for the chunk sorted spatial index.
package csi_pkg;

    localparam int TABLE_CAPACITY = 256;
    localparam int ADDR_W = 8;
    localparam int CNT_W = 9;

    localparam logic signed [31:0] I32_TOP = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] I32_BOT = 32'sh8000_0000;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;
    localparam logic [1:0] ACT_READ   = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_PARTIAL = 2'd1;
    localparam logic [1:0] ST_BEYOND  = 2'd2;

    localparam int KEY_W = 224;

    // One table row: sort key plus the six box coordinates.
    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [63:0] structure;
        logic [63:0] region;
        logic [5:0][63:0] box;
    } row_t;

    // Key as one unsigned word: flipping the sign bits makes the signed
    // chunk fields order correctly under an unsigned compare.
    function automatic logic [KEY_W-1:0] key_word(input row_t r);
        key_word = {~r.cx[31], r.cx[30:0], ~r.cy[31], r.cy[30:0],
                    ~r.cz[31], r.cz[30:0], r.structure, r.region};
    endfunction

endpackage

// ===== src/csi_div.sv =====
// Serial floor divider of a signed coordinate by the chunk size, clamped to 32 bits.
module csi_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] dividend,
    input  logic [62:0]        divisor,
    output logic               done,
    output logic signed [31:0] chunk
);
    import csi_pkg::*;

    logic               busy_reg, busy_next;
    logic               fin_reg, fin_next;
    logic               done_reg, done_next;
    logic               neg_reg, neg_next;
    logic [63:0]        mag_reg, mag_next;
    logic [63:0]        rem_reg, rem_next;
    logic [63:0]        quo_reg, quo_next;
    logic [62:0]        div_reg, div_next;
    logic [6:0]         cnt_reg, cnt_next;
    logic signed [31:0] chunk_reg, chunk_next;
    logic [63:0]        trial;
    logic signed [65:0] q_full;

    assign trial  = {rem_reg[62:0], mag_reg[63]};
    assign q_full = neg_reg ? (-$signed({2'b00, quo_reg}) - ((rem_reg != 64'd0) ? 66'sd1 : 66'sd0))
                            : $signed({2'b00, quo_reg});

    // One quotient bit per cycle, then a registered sign fix and clamp step.
    always_comb
    begin
        busy_next  = busy_reg;
        fin_next   = 1'b0;
        done_next  = 1'b0;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        chunk_next = chunk_reg;
        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = dividend[63];
            mag_next  = dividend[63] ? 64'(-dividend) : 64'(dividend);
            rem_next  = 64'd0;
            quo_next  = 64'd0;
            div_next  = divisor;
            cnt_next  = 7'd0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = trial - {1'b0, div_reg};
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            mag_next = {mag_reg[62:0], 1'b0};
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            if (q_full > 66'(I32_TOP))
                chunk_next = I32_TOP;
            else if (q_full < 66'(I32_BOT))
                chunk_next = I32_BOT;
            else
                chunk_next = q_full[31:0];
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        div_reg   <= div_next;
        cnt_reg   <= cnt_next;
        chunk_reg <= chunk_next;
    end

    assign done  = done_reg;
    assign chunk = chunk_reg;

endmodule

// ===== src/chunk_sorted_spatial_index_top.sv =====
// Top level of the chunk sorted spatial index: table memory and command sequencer.
//
// An item is taken when start is high and busy is low; its result appears for one cycle
// with done high and must be captured then, since the receiver cannot stall. Remove reads
// each held entry once and writes back the kept ones. Insert first runs six serial
// divisions, then per covered chunk a binary search over the table memory, a key check,
// a shift of the entries above the slot up by one place for a new key and a step to place
// the entry and move to the next chunk, all bound by the single read and single write
// port of the memory.
module chunk_sorted_spatial_index_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           action,
    input  logic [63:0]          structure_id,
    input  logic [63:0]          region_key,
    input  logic signed [63:0]   box_min_x,
    input  logic signed [63:0]   box_min_y,
    input  logic signed [63:0]   box_min_z,
    input  logic signed [63:0]   box_max_x,
    input  logic signed [63:0]   box_max_y,
    input  logic signed [63:0]   box_max_z,
    input  logic [7:0]           read_position,
    input  logic [2:0]           read_word,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [62:0]          cfg_data,
    output logic                 done,
    output logic [1:0]           status,
    output logic [8:0]           removed_count,
    output logic [8:0]           entry_count,
    output logic [31:0]          refused_count,
    output logic signed [31:0]   read_chunk_x,
    output logic signed [31:0]   read_chunk_y,
    output logic signed [31:0]   read_chunk_z,
    output logic [63:0]          read_structure,
    output logic [63:0]          read_region,
    output logic signed [63:0]   read_coordinate
);
    import csi_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DIV_GO   = 4'd1;
    localparam logic [3:0] S_DIV_WAIT = 4'd2;
    localparam logic [3:0] S_AXES     = 4'd3;
    localparam logic [3:0] S_SRCH_RD  = 4'd4;
    localparam logic [3:0] S_SRCH_CMP = 4'd5;
    localparam logic [3:0] S_EQ_CMP   = 4'd6;
    localparam logic [3:0] S_PLACE    = 4'd7;
    localparam logic [3:0] S_SHIFT_RD = 4'd8;
    localparam logic [3:0] S_SHIFT_WR = 4'd9;
    localparam logic [3:0] S_NEXT     = 4'd10;
    localparam logic [3:0] S_RM_RD    = 4'd11;
    localparam logic [3:0] S_RM_CHK   = 4'd12;
    localparam logic [3:0] S_RD_OUT   = 4'd13;
    localparam logic [3:0] S_FILL     = 4'd14;

    // Table memory, one row per entry.
    row_t mem [TABLE_CAPACITY];
    row_t rdata;
    logic              rd_en, wr_en;
    logic [ADDR_W-1:0] raddr, waddr;
    row_t              wdata;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[waddr] <= wdata;
        if (rd_en)
            rdata <= mem[raddr];
    end

    logic [3:0]             state_reg, state_next;
    logic [62:0]            csize_reg, csize_next;
    logic [CNT_W-1:0]       used_reg, used_next;
    logic [31:0]            refusals_reg, refusals_next;
    logic [63:0]            sid_reg, sid_next;
    logic [63:0]            rkey_reg, rkey_next;
    logic [5:0][63:0]       box_reg, box_next;
    logic [2:0]             rword_reg, rword_next;
    logic [2:0]             didx_reg, didx_next;
    logic [5:0][31:0]       cq_reg, cq_next;
    logic signed [31:0]     lox_reg, lox_next, loy_reg, loy_next;
    logic signed [31:0]     hix_reg, hix_next, hiy_reg, hiy_next, hiz_reg, hiz_next;
    logic signed [31:0]     x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [CNT_W-1:0]       lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [CNT_W-1:0]       i_reg, i_next, j_reg, j_next;
    logic [CNT_W-1:0]       rmv_reg, rmv_next;

    logic                   done_reg, done_next;
    logic [1:0]             status_reg, status_next;
    logic [8:0]             rmc_reg, rmc_next;
    logic signed [31:0]     ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next;
    logic [63:0]            os_reg, os_next, or_reg, or_next, oc_reg, oc_next;

    logic                   div_start, div_done;
    logic signed [31:0]     div_chunk;
    row_t                   new_row;
    logic [KEY_W-1:0]       nk, rk;
    logic                   key_le, key_eq;
    logic [CNT_W-1:0]       mid_calc;

    csi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (box_reg[didx_reg]),
        .divisor  (csize_reg),
        .done     (div_done),
        .chunk    (div_chunk)
    );

    // New entry for the chunk being visited, and its order against the row read.
    always_comb
    begin
        new_row.cx        = x_reg;
        new_row.cy        = y_reg;
        new_row.cz        = z_reg;
        new_row.structure = sid_reg;
        new_row.region    = rkey_reg;
        new_row.box       = box_reg;
    end

    assign nk       = key_word(new_row);
    assign rk       = key_word(rdata);
    assign key_le   = (nk <= rk);
    assign key_eq   = (nk == rk);
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);

    // Command sequencer.
    always_comb
    begin
        state_next    = state_reg;
        csize_next    = csize_reg;
        used_next     = used_reg;
        refusals_next = refusals_reg;
        sid_next      = sid_reg;
        rkey_next     = rkey_reg;
        box_next      = box_reg;
        rword_next    = rword_reg;
        didx_next     = didx_reg;
        cq_next       = cq_reg;
        lox_next      = lox_reg;
        loy_next      = loy_reg;
        hix_next      = hix_reg;
        hiy_next      = hiy_reg;
        hiz_next      = hiz_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        z_next        = z_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        rmv_next      = rmv_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        rmc_next      = rmc_reg;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        oz_next       = oz_reg;
        os_next       = os_reg;
        or_next       = or_reg;
        oc_next       = oc_reg;
        div_start     = 1'b0;
        rd_en         = 1'b0;
        raddr         = '0;
        wr_en         = 1'b0;
        waddr         = '0;
        wdata         = new_row;

        if (cfg_valid)
            csize_next = cfg_data;

        unique case (state_reg)
            S_IDLE:
            begin
                // While the result is out the block is still busy.
                if (start && !done_reg)
                begin
                    sid_next   = structure_id;
                    rkey_next  = region_key;
                    box_next   = {box_max_z, box_max_y, box_max_x,
                                  box_min_z, box_min_y, box_min_x};
                    rword_next = read_word;
                    // Default result: nothing read, nothing removed.
                    status_next = ST_DONE;
                    rmc_next    = '0;
                    ox_next     = '0;
                    oy_next     = '0;
                    oz_next     = '0;
                    os_next     = '0;
                    or_next     = '0;
                    oc_next     = '0;
                    unique case (action)
                        ACT_INSERT:
                        begin
                            if (csize_reg == 63'd0)
                                done_next = 1'b1;
                            else
                            begin
                                didx_next  = 3'd0;
                                state_next = S_DIV_GO;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (structure_id == 64'd0)
                                done_next = 1'b1;
                            else
                            begin
                                i_next     = '0;
                                j_next     = '0;
                                rmv_next   = '0;
                                state_next = S_RM_RD;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            used_next = '0;
                            done_next = 1'b1;
                        end
                        ACT_READ:
                        begin
                            if ({1'b0, read_position} >= used_reg)
                            begin
                                status_next = ST_BEYOND;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                raddr      = read_position;
                                state_next = S_RD_OUT;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_RD_OUT:
            begin
                ox_next = rdata.cx;
                oy_next = rdata.cy;
                oz_next = rdata.cz;
                os_next = rdata.structure;
                or_next = rdata.region;
                oc_next = (rword_reg <= 3'd5) ? rdata.box[rword_reg] : 64'd0;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end

            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    cq_next[didx_reg] = div_chunk;
                    if (didx_reg == 3'd5)
                        state_next = S_AXES;
                    else
                    begin
                        didx_next  = didx_reg + 3'd1;
                        state_next = S_DIV_GO;
                    end
                end
            end

            // Order each axis range and start at its low corner.
            S_AXES:
            begin
                if ($signed(cq_reg[0]) < $signed(cq_reg[3]))
                begin
                    lox_next = cq_reg[0];
                    hix_next = cq_reg[3];
                end
                else
                begin
                    lox_next = cq_reg[3];
                    hix_next = cq_reg[0];
                end
                if ($signed(cq_reg[1]) < $signed(cq_reg[4]))
                begin
                    loy_next = cq_reg[1];
                    hiy_next = cq_reg[4];
                end
                else
                begin
                    loy_next = cq_reg[4];
                    hiy_next = cq_reg[1];
                end
                if ($signed(cq_reg[2]) < $signed(cq_reg[5]))
                begin
                    z_next   = cq_reg[2];
                    hiz_next = cq_reg[5];
                end
                else
                begin
                    z_next   = cq_reg[5];
                    hiz_next = cq_reg[2];
                end
                x_next     = lox_next;
                y_next     = loy_next;
                lo_next    = '0;
                hi_next    = used_reg;
                state_next = S_SRCH_RD;
            end

            // Lower-bound search for the visited key.
            S_SRCH_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_calc;
                    rd_en      = 1'b1;
                    raddr      = mid_calc[ADDR_W-1:0];
                    state_next = S_SRCH_CMP;
                end
                else if (lo_reg < used_reg)
                begin
                    rd_en      = 1'b1;
                    raddr      = lo_reg[ADDR_W-1:0];
                    state_next = S_EQ_CMP;
                end
                else
                    state_next = S_PLACE;
            end

            S_SRCH_CMP:
            begin
                if (key_le)
                    hi_next = mid_reg;
                else
                    lo_next = mid_reg + 1'b1;
                state_next = S_SRCH_RD;
            end

            // Existing key: overwrite the box in place.
            S_EQ_CMP:
            begin
                if (key_eq)
                begin
                    wr_en      = 1'b1;
                    waddr      = lo_reg[ADDR_W-1:0];
                    state_next = S_NEXT;
                end
                else
                    state_next = S_PLACE;
            end

            S_PLACE:
            begin
                if (used_reg >= CNT_W'(TABLE_CAPACITY))
                begin
                    refusals_next = refusals_reg + 32'd1;
                    status_next   = ST_PARTIAL;
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (used_reg > lo_reg)
                begin
                    i_next     = used_reg;
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    wr_en      = 1'b1;
                    waddr      = lo_reg[ADDR_W-1:0];
                    used_next  = used_reg + 1'b1;
                    state_next = S_NEXT;
                end
            end

            // Move entries up one place, top first, to open the slot.
            S_SHIFT_RD:
            begin
                rd_en      = 1'b1;
                raddr      = ADDR_W'(i_reg - 1'b1);
                state_next = S_SHIFT_WR;
            end

            S_SHIFT_WR:
            begin
                wr_en  = 1'b1;
                waddr  = i_reg[ADDR_W-1:0];
                wdata  = rdata;
                i_next = i_reg - 1'b1;
                if (i_reg - 1'b1 == lo_reg)
                    state_next = S_FILL;
                else
                    state_next = S_SHIFT_RD;
            end

            // The slot is open: write the new entry into it.
            S_FILL:
            begin
                wr_en      = 1'b1;
                waddr      = lo_reg[ADDR_W-1:0];
                used_next  = used_reg + 1'b1;
                state_next = S_NEXT;
            end

            // Step to the next chunk, x innermost.
            S_NEXT:
            begin
                lo_next    = '0;
                hi_next    = used_reg;
                state_next = S_SRCH_RD;
                if (x_reg != hix_reg)
                    x_next = x_reg + 32'sd1;
                else
                begin
                    x_next = lox_reg;
                    if (y_reg != hiy_reg)
                        y_next = y_reg + 32'sd1;
                    else
                    begin
                        y_next = loy_reg;
                        if (z_reg != hiz_reg)
                            z_next = z_reg + 32'sd1;
                        else
                        begin
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                end
            end

            // Compaction: keep rows of other structures, drop the matching ones.
            S_RM_RD:
            begin
                if (i_reg < used_reg)
                begin
                    rd_en      = 1'b1;
                    raddr      = i_reg[ADDR_W-1:0];
                    state_next = S_RM_CHK;
                end
                else
                begin
                    used_next  = j_reg;
                    rmc_next   = rmv_reg;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_RM_CHK:
            begin
                if (rdata.structure == sid_reg)
                    rmv_next = rmv_reg + 1'b1;
                else
                begin
                    wr_en  = 1'b1;
                    waddr  = j_reg[ADDR_W-1:0];
                    wdata  = rdata;
                    j_next = j_reg + 1'b1;
                end
                i_next     = i_reg + 1'b1;
                state_next = S_RM_RD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            csize_reg    <= 63'd65536;
            used_reg     <= '0;
            refusals_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            csize_reg    <= csize_next;
            used_reg     <= used_next;
            refusals_reg <= refusals_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sid_reg    <= sid_next;
        rkey_reg   <= rkey_next;
        box_reg    <= box_next;
        rword_reg  <= rword_next;
        didx_reg   <= didx_next;
        cq_reg     <= cq_next;
        lox_reg    <= lox_next;
        loy_reg    <= loy_next;
        hix_reg    <= hix_next;
        hiy_reg    <= hiy_next;
        hiz_reg    <= hiz_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        rmv_reg    <= rmv_next;
        status_reg <= status_next;
        rmc_reg    <= rmc_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        oz_reg     <= oz_next;
        os_reg     <= os_next;
        or_reg     <= or_next;
        oc_reg     <= oc_next;
    end

    assign busy            = (state_reg != S_IDLE) || done_reg;
    assign cfg_ready       = 1'b1;
    assign done            = done_reg;
    assign status          = status_reg;
    assign removed_count   = rmc_reg;
    assign entry_count     = used_reg;
    assign refused_count   = refusals_reg;
    assign read_chunk_x    = ox_reg;
    assign read_chunk_y    = oy_reg;
    assign read_chunk_z    = oz_reg;
    assign read_structure  = os_reg;
    assign read_region     = or_reg;
    assign read_coordinate = oc_reg;

endmodule
